// ----- design/present_pkg.sv -----
package present_pkg;

    localparam int ROUNDS = 32;
    localparam int RND_W  = $clog2(ROUNDS);

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_HIGH   = 3'd0,
        CFG_KEY_LOW    = 3'd1,
        CFG_KEY_SIZE   = 3'd2,
        CFG_INIT_VEC   = 3'd3,
        CFG_CHAIN_EN   = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC,
        ST_DKEY,
        ST_DEC,
        ST_DONE
    } state_t;

    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    localparam logic [3:0] SBOX_INV [16] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    function automatic logic [63:0] sub_fwd(input logic [63:0] s);
        logic [63:0] r;
        for (int n = 0; n < 16; n++)
        begin
            r[4*n +: 4] = SBOX[s[4*n +: 4]];
        end
        return r;
    endfunction

    function automatic logic [63:0] sub_inv(input logic [63:0] s);
        logic [63:0] r;
        for (int n = 0; n < 16; n++)
        begin
            r[4*n +: 4] = SBOX_INV[s[4*n +: 4]];
        end
        return r;
    endfunction

    // bit i moves to 16*i mod 63, bit 63 stays
    function automatic logic [63:0] perm_fwd(input logic [63:0] s);
        logic [63:0] r;
        for (int i = 0; i < 63; i++)
        begin
            r[(16*i) % 63] = s[i];
        end
        r[63] = s[63];
        return r;
    endfunction

    function automatic logic [63:0] perm_inv(input logic [63:0] s);
        logic [63:0] r;
        for (int j = 0; j < 63; j++)
        begin
            r[j] = s[(16*j) % 63];
        end
        r[63] = s[63];
        return r;
    endfunction

    // 80-bit keys live in k[127:48]; the low 48 bits ride along unused
    function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic mode,
                                             input logic [RND_W-1:0] rc);
        logic [79:0]  k80;
        logic [127:0] r;
        k80 = k[127:48];
        r   = k;
        if (mode)
        begin
            r = {k[66:0], k[127:67]};
            r[127:124] = SBOX[r[127:124]];
            r[123:120] = SBOX[r[123:120]];
            r[66:62]   = r[66:62] ^ rc;
        end
        else
        begin
            k80 = {k80[18:0], k80[79:19]};
            k80[79:76] = SBOX[k80[79:76]];
            k80[19:15] = k80[19:15] ^ rc;
            r = {k80, k[47:0]};
        end
        return r;
    endfunction

    function automatic logic [127:0] key_inv(input logic [127:0] k, input logic mode,
                                             input logic [RND_W-1:0] rc);
        logic [79:0]  k80;
        logic [127:0] r;
        k80 = k[127:48];
        r   = k;
        if (mode)
        begin
            r[66:62]   = r[66:62] ^ rc;
            r[127:124] = SBOX_INV[r[127:124]];
            r[123:120] = SBOX_INV[r[123:120]];
            r = {r[60:0], r[127:61]};
        end
        else
        begin
            k80[19:15] = k80[19:15] ^ rc;
            k80[79:76] = SBOX_INV[k80[79:76]];
            k80 = {k80[60:0], k80[79:61]};
            r = {k80, k[47:0]};
        end
        return r;
    endfunction

endpackage

// ----- design/present_cbc_cipher.sv -----
// PRESENT 64-bit block cipher, 80- or 128-bit key, with optional CBC chaining.
// Input channel (blk_valid/blk_ready) carries one block per beat: kind
// (0 encrypt, 1 decrypt), data_block and first_of_message, which restarts the
// chain from the IV. Output channel (res_valid/res_ready) returns one
// result_block per input beat, in order.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) with
// registers key_high, key_low, key_size_mode, init_vector, chaining_enable;
// write it only while no block is in flight.
// One round unit and one key-schedule step are reused each cycle. An encrypt
// beat runs 31 rounds and then a final key add before res_valid.
// A decrypt beat first runs 31 forward key-schedule steps to reach the
// last round key, then 31 inverse rounds walking the schedule backwards.
// One block is in flight at a time; the next is accepted once the result has
// moved into the output register. If the receiver stalls, the finished block
// waits in the core until the output register frees up.
// Reset clears the chain value, the key, IV and mode registers, and sets
// chaining on; no result is pending after reset.
module present_cbc_cipher
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [present_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                         cfg_data,

    input  logic                                blk_valid,
    output logic                                blk_ready,
    input  logic                                kind,
    input  logic [63:0]                         data_block,
    input  logic                                first_of_message,

    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [63:0]                         result_block
);

    localparam logic [present_pkg::RND_W-1:0] LAST_RND =
        present_pkg::RND_W'(present_pkg::ROUNDS - 2);
    localparam logic [present_pkg::RND_W-1:0] TOP_RND =
        present_pkg::RND_W'(present_pkg::ROUNDS - 1);
    localparam logic [present_pkg::RND_W-1:0] ONE_RND =
        present_pkg::RND_W'(1);

    present_pkg::state_t state_reg, state_next;

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    logic         key_size_mode_reg;
    logic [63:0]  init_vector_reg;
    logic         chaining_enable_reg;
    logic [63:0]  chain_value_reg;

    logic [present_pkg::RND_W-1:0] rnd_reg;
    logic         res_valid_reg;
    logic [63:0]  result_reg;

    logic [63:0]  st_reg;
    logic [127:0] key_reg;
    logic [63:0]  prev_reg;
    logic [63:0]  din_reg;
    logic         dec_reg;

    logic         accept;
    logic         out_load;
    logic [63:0]  prev_sel;
    logic [63:0]  whitened;
    logic [63:0]  rnd_fwd;
    logic [63:0]  rnd_inv;
    logic [127:0] key_step_fwd;
    logic [127:0] key_step_inv;
    logic [63:0]  result_next;
    logic [63:0]  chain_value_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            present_pkg::ST_IDLE:
            begin
                if (blk_valid)
                begin
                    state_next = kind ? present_pkg::ST_DKEY : present_pkg::ST_ENC;
                end
            end
            present_pkg::ST_ENC:
            begin
                if (rnd_reg == LAST_RND)
                begin
                    state_next = present_pkg::ST_DONE;
                end
            end
            present_pkg::ST_DKEY:
            begin
                if (rnd_reg == LAST_RND)
                begin
                    state_next = present_pkg::ST_DEC;
                end
            end
            present_pkg::ST_DEC:
            begin
                if (rnd_reg == ONE_RND)
                begin
                    state_next = present_pkg::ST_DONE;
                end
            end
            present_pkg::ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next = present_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = present_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        blk_ready = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            present_pkg::ST_IDLE:
            begin
                blk_ready = 1'b1;
            end
            present_pkg::ST_DONE:
            begin
                out_load = !res_valid_reg || res_ready;
            end
            default:
            begin
                blk_ready = 1'b0;
            end
        endcase
    end

    assign accept       = blk_valid && blk_ready;
    assign res_valid    = res_valid_reg;
    assign result_block = result_reg;

    // shared round and key-schedule logic
    assign prev_sel     = first_of_message ? init_vector_reg : chain_value_reg;
    assign whitened     = st_reg ^ key_reg[127:64];
    assign rnd_fwd      = present_pkg::perm_fwd(present_pkg::sub_fwd(whitened));
    assign rnd_inv      = present_pkg::sub_inv(present_pkg::perm_inv(whitened));
    assign key_step_fwd = present_pkg::key_fwd(key_reg, key_size_mode_reg,
                                               rnd_reg + ONE_RND);
    assign key_step_inv = present_pkg::key_inv(key_reg, key_size_mode_reg, rnd_reg);

    assign result_next      = (dec_reg && chaining_enable_reg) ? (whitened ^ prev_reg)
                                                               : whitened;
    assign chain_value_next = dec_reg ? din_reg : whitened;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= present_pkg::ST_IDLE;
            rnd_reg             <= '0;
            res_valid_reg       <= 1'b0;
            key_high_reg        <= '0;
            key_low_reg         <= '0;
            key_size_mode_reg   <= 1'b0;
            init_vector_reg     <= '0;
            chaining_enable_reg <= 1'b1;
            chain_value_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    present_pkg::CFG_KEY_HIGH: key_high_reg        <= cfg_data;
                    present_pkg::CFG_KEY_LOW:  key_low_reg         <= cfg_data;
                    present_pkg::CFG_KEY_SIZE: key_size_mode_reg   <= cfg_data[0];
                    present_pkg::CFG_INIT_VEC: init_vector_reg     <= cfg_data;
                    present_pkg::CFG_CHAIN_EN: chaining_enable_reg <= cfg_data[0];
                    default:                   ;
                endcase
            end

            unique case (state_reg)
                present_pkg::ST_IDLE:
                begin
                    rnd_reg <= '0;
                end
                present_pkg::ST_ENC:
                begin
                    rnd_reg <= rnd_reg + ONE_RND;
                end
                present_pkg::ST_DKEY:
                begin
                    rnd_reg <= (rnd_reg == LAST_RND) ? TOP_RND : rnd_reg + ONE_RND;
                end
                present_pkg::ST_DEC:
                begin
                    rnd_reg <= rnd_reg - ONE_RND;
                end
                default:
                begin
                    rnd_reg <= rnd_reg;
                end
            endcase

            if (out_load)
            begin
                res_valid_reg   <= 1'b1;
                chain_value_reg <= chain_value_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= result_next;
        end

        unique case (state_reg)
            present_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    dec_reg  <= kind;
                    din_reg  <= data_block;
                    prev_reg <= prev_sel;
                    key_reg  <= {key_high_reg, key_low_reg};
                    st_reg   <= (!kind && chaining_enable_reg) ? (data_block ^ prev_sel)
                                                               : data_block;
                end
            end
            present_pkg::ST_ENC:
            begin
                st_reg  <= rnd_fwd;
                key_reg <= key_step_fwd;
            end
            present_pkg::ST_DKEY:
            begin
                key_reg <= key_step_fwd;
            end
            present_pkg::ST_DEC:
            begin
                st_reg  <= rnd_inv;
                key_reg <= key_step_inv;
            end
            default:
            begin
                st_reg <= st_reg;
            end
        endcase
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_ROUND_KEYS = 32;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int DRAIN_CYCLES   = 70;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [3:0] FWD_BOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };
    localparam logic [3:0] INV_BOX [16] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    typedef struct packed {
        logic        kind;
        logic [63:0] data;
        logic        first;
    } block_beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                                cfg_we    = 1'b0;
    logic [present_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [63:0]                         cfg_data  = '0;

    logic        blk_valid        = 1'b0;
    logic        blk_ready;
    logic        kind             = 1'b0;
    logic [63:0] data_block       = '0;
    logic        first_of_message = 1'b0;

    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [63:0] result_block;

    // shadow of the block's registers and chain state
    logic [63:0] cfg_key_high = '0;
    logic [63:0] cfg_key_low  = '0;
    logic        cfg_key_wide = 1'b0;
    logic [63:0] cfg_iv       = '0;
    logic        cfg_chain_en = 1'b1;
    logic [63:0] chain_reg    = '0;

    block_beat_t pending_blocks[$];
    block_beat_t beat_on_bus;
    logic [63:0] expected_results[$];
    logic [63:0] want;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned blocks_queued  = 0;

    present_cbc_cipher dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .blk_valid        (blk_valid),
        .blk_ready        (blk_ready),
        .kind             (kind),
        .data_block       (data_block),
        .first_of_message (first_of_message),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .result_block     (result_block)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] sbox_layer(input logic [63:0] s, input logic inverse);
        logic [63:0] r;
        for (int n = 0; n < 16; n++)
        begin
            r[4*n +: 4] = inverse ? INV_BOX[s[4*n +: 4]] : FWD_BOX[s[4*n +: 4]];
        end
        return r;
    endfunction

    // bit i travels to 16*i mod 63; the top bit stays put
    function automatic logic [63:0] bit_perm(input logic [63:0] s, input logic inverse);
        logic [63:0] r;
        int          dst;
        r = s;
        for (int i = 0; i < 63; i++)
        begin
            dst = (16 * i) % 63;
            if (inverse)
                r[i] = s[dst];
            else
                r[dst] = s[i];
        end
        return r;
    endfunction

    function automatic logic [63:0] present_core(input logic [63:0] blk, input logic decrypt);
        logic [63:0]  rk [NUM_ROUND_KEYS];
        logic [127:0] k128;
        logic [79:0]  k80;
        logic [4:0]   rc;
        logic [63:0]  s;
        k128  = {cfg_key_high, cfg_key_low};
        k80   = {cfg_key_high, cfg_key_low[63:48]};
        rk[0] = cfg_key_high;
        for (int r = 1; r < NUM_ROUND_KEYS; r++)
        begin
            rc = 5'(r);
            if (cfg_key_wide)
            begin
                k128 = {k128[66:0], k128[127:67]};
                k128[127:124] = FWD_BOX[k128[127:124]];
                k128[123:120] = FWD_BOX[k128[123:120]];
                k128[66:62]   = k128[66:62] ^ rc;
                rk[r] = k128[127:64];
            end
            else
            begin
                k80 = {k80[18:0], k80[79:19]};
                k80[79:76] = FWD_BOX[k80[79:76]];
                k80[19:15] = k80[19:15] ^ rc;
                rk[r] = k80[79:16];
            end
        end
        s = blk;
        if (!decrypt)
        begin
            for (int r = 0; r < NUM_ROUND_KEYS - 1; r++)
            begin
                s = bit_perm(sbox_layer(s ^ rk[r], 1'b0), 1'b0);
            end
            s = s ^ rk[NUM_ROUND_KEYS - 1];
        end
        else
        begin
            for (int r = NUM_ROUND_KEYS - 1; r > 0; r--)
            begin
                s = sbox_layer(bit_perm(s ^ rk[r], 1'b1), 1'b1);
            end
            s = s ^ rk[0];
        end
        return s;
    endfunction

    // chain always follows the ciphertext side of the beat
    function automatic logic [63:0] cbc_predict(input block_beat_t b);
        logic [63:0] prev;
        logic [63:0] res;
        prev = b.first ? cfg_iv : chain_reg;
        if (b.kind == OP_DECRYPT)
        begin
            res = present_core(b.data, 1'b1);
            if (cfg_chain_en)
                res = res ^ prev;
            chain_reg = b.data;
        end
        else
        begin
            res = present_core(cfg_chain_en ? (b.data ^ prev) : b.data, 1'b0);
            chain_reg = res;
        end
        return res;
    endfunction

    function automatic logic [63:0] random_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid <= 1'b0;
        end
        else
        begin
            if (blk_valid && blk_ready)
                expected_results.push_back(cbc_predict(beat_on_bus));
            if (!blk_valid || blk_ready)
            begin
                if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    beat_on_bus = pending_blocks.pop_front();
                    blk_valid        <= 1'b1;
                    kind             <= beat_on_bus.kind;
                    data_block       <= beat_on_bus.data;
                    first_of_message <= beat_on_bus.first;
                end
                else
                begin
                    blk_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result_block: expected none, actual %h", result_block);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_block !== want)
                    begin
                        $error("result_block: expected %h, actual %h", want, result_block);
                        error_count++;
                    end
                end
            end
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic cfg_write(input present_pkg::cfg_idx_t idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            present_pkg::CFG_KEY_HIGH: cfg_key_high = value;
            present_pkg::CFG_KEY_LOW:  cfg_key_low  = value;
            present_pkg::CFG_KEY_SIZE: cfg_key_wide = value[0];
            present_pkg::CFG_INIT_VEC: cfg_iv       = value;
            present_pkg::CFG_CHAIN_EN: cfg_chain_en = value[0];
            default: ;
        endcase
    endtask

    task automatic queue_block(input logic op, input logic [63:0] data, input logic first);
        block_beat_t b;
        b.kind  = op;
        b.data  = data;
        b.first = first;
        pending_blocks.push_back(b);
        blocks_queued++;
    endtask

    // well-formed message most of the time; sometimes unflagged or mixed kinds
    task automatic queue_message();
        int   len;
        logic op;
        logic mixed;
        logic flagged;
        len     = $urandom_range(8, 1);
        op      = ($urandom_range(1) == 1);
        mixed   = ($urandom_range(9) == 0);
        flagged = ($urandom_range(9) != 0);
        for (int i = 0; i < len; i++)
        begin
            queue_block(mixed ? ($urandom_range(1) == 1) : op, random_word(),
                        (i == 0) ? flagged : ($urandom_range(49) == 0));
        end
    endtask

    // sampled on the falling edge so the sender's updates have settled
    task automatic wait_quiet();
        @(negedge clk);
        while (pending_blocks.size() != 0 || blk_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int unsigned target;

        if (present_core(64'h0, 1'b0) !== 64'h5579C1387B228445)
        begin
            $error("predictor: expected %h, actual %h", 64'h5579C1387B228445,
                   present_core(64'h0, 1'b0));
            error_count++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings; unflagged blocks chain from a zero chain value
        @(negedge clk);
        queue_block(OP_ENCRYPT, 64'h0, 1'b0);
        queue_block(OP_ENCRYPT, '1, 1'b0);
        queue_block(OP_DECRYPT, '1, 1'b0);
        wait_quiet();

        cfg_write(present_pkg::CFG_CHAIN_EN, 64'h0);
        @(negedge clk);
        queue_block(OP_ENCRYPT, 64'h0, 1'b1);
        queue_block(OP_DECRYPT, 64'h0, 1'b1);
        wait_quiet();

        // 80-bit key all ones; low bits of key_low are don't-care here
        cfg_write(present_pkg::CFG_KEY_HIGH, '1);
        cfg_write(present_pkg::CFG_KEY_LOW, '1);
        @(negedge clk);
        queue_block(OP_ENCRYPT, 64'h0, 1'b0);
        queue_block(OP_ENCRYPT, '1, 1'b0);
        queue_block(OP_DECRYPT, 64'h5555_5555_5555_5555, 1'b0);
        wait_quiet();

        cfg_write(present_pkg::CFG_KEY_SIZE, 64'h1);
        cfg_write(present_pkg::CFG_KEY_HIGH, 64'h0123_4567_89AB_CDEF);
        cfg_write(present_pkg::CFG_KEY_LOW, 64'hFEDC_BA98_7654_3210);
        cfg_write(present_pkg::CFG_INIT_VEC, '1);
        cfg_write(present_pkg::CFG_CHAIN_EN, 64'h1);
        @(negedge clk);
        queue_block(OP_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        queue_block(OP_ENCRYPT, 64'h0, 1'b0);
        queue_block(OP_DECRYPT, 64'h8000_0000_0000_0001, 1'b0);
        queue_block(OP_DECRYPT, 64'h0F0F_0F0F_F0F0_F0F0, 1'b1);
        queue_block(OP_ENCRYPT, 64'h1234_5678_9ABC_DEF0, 1'b0);
        wait_quiet();

        // key swap mid-message: chain carries on
        cfg_write(present_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
        @(negedge clk);
        queue_block(OP_ENCRYPT, {$urandom, $urandom}, 1'b0);
        queue_block(OP_DECRYPT, {$urandom, $urandom}, 1'b0);
        wait_quiet();

        cfg_write(present_pkg::CFG_KEY_HIGH, '1);
        cfg_write(present_pkg::CFG_KEY_LOW, '1);
        cfg_write(present_pkg::CFG_INIT_VEC, 64'h0);
        @(negedge clk);
        queue_block(OP_ENCRYPT, '1, 1'b1);
        queue_block(OP_DECRYPT, 64'h0, 1'b0);

        for (int phase = 0; phase < 4; phase++)
        begin
            for (int seg = 0; seg < 5; seg++)
            begin
                wait_quiet();
                case (phase)
                    0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
                    2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
                    default: begin send_idle_pct = 37; recv_stall_pct = 37; end
                endcase
                cfg_write(present_pkg::CFG_KEY_HIGH, random_word());
                cfg_write(present_pkg::CFG_KEY_LOW, random_word());
                cfg_write(present_pkg::CFG_KEY_SIZE, {63'h0, $urandom_range(1) == 1});
                cfg_write(present_pkg::CFG_INIT_VEC, random_word());
                cfg_write(present_pkg::CFG_CHAIN_EN, {63'h0, $urandom_range(3) != 0});
                @(negedge clk);
                target = blocks_queued + 85;
                while (blocks_queued < target)
                    queue_message();
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
